// ===== rtl/core/crypto1_pkg.sv =====
// Shared types, constants and LFSR functions for the Crypto-1 stream cipher core.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crypto1_pkg;

  localparam int HALF_W    = 24;
  localparam int KEY_W     = 48;
  localparam int IV_W      = 64;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int INIT_N    = 4;
  localparam int INIT_CNT_W = $clog2(INIT_N);

  localparam logic [CFG_IDX_W-1:0] REG_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IV  = 2'd1;

  localparam logic [HALF_W-1:0] FB_MASK_ODD  = 24'h29CE5C;
  localparam logic [HALF_W-1:0] FB_MASK_EVEN = 24'h870804;
  localparam logic [HALF_W-1:0] FLT_MASK0    = 24'h0F22C0;
  localparam logic [HALF_W-1:0] FLT_MASK1    = 24'h06C9C0;
  localparam logic [HALF_W-1:0] FLT_MASK2    = 24'h03C8B0;
  localparam logic [HALF_W-1:0] FLT_MASK3    = 24'h01E458;
  localparam logic [HALF_W-1:0] FLT_MASK4    = 24'h00D938;
  localparam logic [31:0]       FLT_OUT      = 32'hEC57E80A;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INIT = 3'b010,
    S_DATA = 3'b100
  } crypto1_state_t;

  typedef struct packed {
    logic                  load_key;
    logic                  init_step;
    logic [INIT_CNT_W-1:0] init_idx;
    logic                  data_step;
    logic                  use_held;
    logic                  hold_data;
  } crypto1_cmd_t;

  typedef struct packed {
    logic out_free;
  } crypto1_sts_t;

  typedef struct packed {
    logic [HALF_W-1:0] odd_half;
    logic [HALF_W-1:0] even_half;
  } crypto1_lfsr_t;

  typedef struct packed {
    crypto1_lfsr_t     lfsr;
    logic [BYTE_W-1:0] ks;
  } crypto1_byte_res_t;

  function automatic logic filter_bit(input logic [HALF_W-1:0] x);
    logic [4:0] f;
    f[4] = FLT_MASK0[5'(x[3:0])   + 5'd4];
    f[3] = FLT_MASK1[5'(x[7:4])   + 5'd3];
    f[2] = FLT_MASK2[5'(x[11:8])  + 5'd2];
    f[1] = FLT_MASK3[5'(x[15:12]) + 5'd1];
    f[0] = FLT_MASK4[5'(x[19:16])];
    return FLT_OUT[f];
  endfunction

  function automatic crypto1_byte_res_t clock_byte(input crypto1_lfsr_t st,
                                                   input logic [BYTE_W-1:0] din);
    crypto1_byte_res_t res;
    logic [HALF_W-1:0] odd_v;
    logic [HALF_W-1:0] even_v;
    logic [HALF_W-1:0] newer;
    logic              fb;
    odd_v  = st.odd_half;
    even_v = st.even_half;
    res.ks = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      res.ks[k] = filter_bit(odd_v);
      fb        = din[k] ^ (^(FB_MASK_ODD & odd_v)) ^ (^(FB_MASK_EVEN & even_v));
      newer     = {even_v[HALF_W-2:0], fb};
      even_v    = odd_v;
      odd_v     = newer;
    end
    res.lfsr.odd_half  = odd_v;
    res.lfsr.even_half = even_v;
    return res;
  endfunction

  function automatic crypto1_lfsr_t key_to_lfsr(input logic [KEY_W-1:0] k);
    crypto1_lfsr_t st;
    for (int j = 0; j < HALF_W; j++) begin
      st.odd_half[HALF_W-1-j]  = k[(46 - 2*j) ^ 7];
      st.even_half[HALF_W-1-j] = k[(47 - 2*j) ^ 7];
    end
    return st;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crypto1_stream_cipher_core.sv =====
// Crypto-1 stream cipher core: top level joining crypto1_ctrl and crypto1_dp.
// Plain beat: taken and encrypted in the accept cycle, result in out_tdata in the following cycle.
// Restart beat: key load in the accept cycle, then the uid/nonce init steps, then the data step.
// Throughput: 1 beat per cycle (8-step LFSR byte unit) while out_tready holds; restart blocks new beats.
// Reset (rst_n, synchronous): key, uid/nonce and LFSR cleared to zero, output empty.
`timescale 1ns / 1ps
`default_nettype none

module crypto1_stream_cipher_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [crypto1_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [crypto1_pkg::IV_W-1:0]       cfg_data,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [crypto1_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  wire                                in_tuser,   // [0] restart
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [crypto1_pkg::BYTE_W-1:0]     out_tdata   // [7:0] out_byte
);
  import crypto1_pkg::*;

  crypto1_cmd_t cmd;
  crypto1_sts_t sts;

  crypto1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  crypto1_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/core/crypto1_ctrl.sv =====
// Sequencer for the Crypto-1 core: input handshake, key load, uid/nonce init, data byte.
// Depends on crypto1_pkg; drives the datapath through crypto1_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module crypto1_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire                       in_tuser,
  input  crypto1_pkg::crypto1_sts_t sts,
  output crypto1_pkg::crypto1_cmd_t cmd
);
  import crypto1_pkg::*;

  crypto1_state_t        state_r, state_nxt;
  logic [INIT_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.init_idx  = cnt_r;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          if (in_tuser) begin
            cmd.load_key  = 1'b1;
            cmd.hold_data = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_INIT;
          end else begin
            cmd.data_step = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == INIT_CNT_W'(INIT_N - 1)) begin
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.data_step = 1'b1;
          cmd.use_held  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crypto1_dp.sv =====
// Datapath for the Crypto-1 core: config registers, LFSR halves, byte clock unit, output register.
// Depends on crypto1_pkg; commanded by crypto1_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module crypto1_dp (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [crypto1_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [crypto1_pkg::IV_W-1:0]           cfg_data,
  input  wire  [crypto1_pkg::BYTE_W-1:0]         in_data,
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  output logic [crypto1_pkg::BYTE_W-1:0]         out_data,
  input  crypto1_pkg::crypto1_cmd_t              cmd,
  output crypto1_pkg::crypto1_sts_t              sts
);
  import crypto1_pkg::*;

  logic [KEY_W-1:0]  key_r;
  logic [IV_W-1:0]   iv_r;
  crypto1_lfsr_t     lfsr_r, lfsr_nxt;
  logic [BYTE_W-1:0] held_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_valid_r, out_valid_nxt;

  logic [31:0]       mix;
  logic [BYTE_W-1:0] init_byte;
  logic [BYTE_W-1:0] unit_in;
  logic [BYTE_W-1:0] data_src;
  crypto1_byte_res_t unit_res;

  assign cfg_ready    = 1'b1;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_data     = out_data_r;

  assign mix = iv_r[63:32] ^ iv_r[31:0];

  always_comb begin
    unique case (cmd.init_idx)
      2'd0:    init_byte = mix[31:24];
      2'd1:    init_byte = mix[23:16];
      2'd2:    init_byte = mix[15:8];
      default: init_byte = mix[7:0];
    endcase
  end

  assign unit_in  = cmd.init_step ? init_byte : '0;
  assign unit_res = clock_byte(lfsr_r, unit_in);
  assign data_src = cmd.use_held ? held_r : in_data;

  always_comb begin
    priority if (cmd.load_key) begin
      lfsr_nxt = key_to_lfsr(key_r);
    end else if (cmd.init_step || cmd.data_step) begin
      lfsr_nxt = unit_res.lfsr;
    end else begin
      lfsr_nxt = lfsr_r;
    end
  end

  always_comb begin
    priority if (cmd.data_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      iv_r        <= '0;
      lfsr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_KEY) begin
        key_r <= cfg_data[KEY_W-1:0];
      end
      if (cfg_valid && cfg_index == REG_IV) begin
        iv_r <= cfg_data;
      end
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_data) begin
      held_r <= in_data;
    end
    if (cmd.data_step) begin
      out_data_r <= data_src ^ unit_res.ks;
    end
  end

endmodule

`default_nettype wire
